// File: hdl/ktsq_pkg.sv
// ktsq_pkg: shared types and operation codes for the keyed timer schedule queue.
// No dependencies.
package ktsq_pkg;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_EXISTS = 2'd2;
  localparam logic [1:0] OP_DROP   = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] due_time;
    logic [63:0] now_time;
    logic [47:0] station_addr;
    logic [7:0]  event_type;
    logic [31:0] payload;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [47:0] out_addr;
    logic [7:0]  out_type;
    logic [31:0] out_payload;
  } rsp_t;

  // one table entry as stored in memory
  typedef struct packed {
    logic [63:0] due;
    logic [47:0] addr;
    logic [7:0]  etype;
    logic [31:0] pay;
  } entry_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load_req;   // capture request
    logic rd_en;      // issue memory read at rd_addr
    logic wr_en;      // write memory at wr_addr
    logic wr_new;     // write data is the new entry, else the last read entry
    logic cnt_inc;
    logic cnt_dec;
    logic set_rsp;    // latch response
    logic rsp_ok;
    logic rsp_data;   // response carries the last read entry
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic key_hit;    // last read entry matches request key
    logic due_le;     // last read entry due <= request due
    logic now_ok;     // last read entry due <= request now
  } sts_t;

endpackage

// File: hdl/ktsq_datapath.sv
// ktsq_datapath: entry memory, slot count, request and response registers.
// Depends on ktsq_pkg.
module ktsq_datapath import ktsq_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 64,
  localparam int unsigned AW = $clog2(TABLE_DEPTH),
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cmd_t          cmd_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic [AW-1:0] wr_addr_i,
  input  req_t          req_i,
  output req_t          req_o,
  output sts_t          sts_o,
  output logic [CW-1:0] count_o,
  output rsp_t          rsp_o
);

  entry_t mem_q [TABLE_DEPTH];
  entry_t rd_q;
  entry_t new_e;
  req_t   req_q;
  rsp_t   rsp_q;
  logic [CW-1:0] count_q;

  assign new_e = '{due: req_q.due_time, addr: req_q.station_addr,
                   etype: req_q.event_type, pay: req_q.payload};

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[rd_addr_i];
    end
    if (cmd_i.wr_en) begin
      mem_q[wr_addr_i] <= cmd_i.wr_new ? new_e : rd_q;
    end
    if (cmd_i.load_req) begin
      req_q <= req_i;
    end
    if (cmd_i.set_rsp) begin
      rsp_q.ok          <= cmd_i.rsp_ok;
      rsp_q.out_addr    <= cmd_i.rsp_data ? rd_q.addr  : '0;
      rsp_q.out_type    <= cmd_i.rsp_data ? rd_q.etype : '0;
      rsp_q.out_payload <= cmd_i.rsp_data ? rd_q.pay   : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      count_q <= count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_q <= count_q - CW'(1);
    end
  end

  assign sts_o.key_hit = (rd_q.addr == req_q.station_addr) &&
                         (rd_q.etype == req_q.event_type);
  assign sts_o.due_le  = rd_q.due <= req_q.due_time;
  assign sts_o.now_ok  = rd_q.due <= req_q.now_time;
  assign count_o = count_q;
  assign req_o   = req_q;
  assign rsp_o   = rsp_q;

endmodule

// File: hdl/ktsq_ctrl.sv
// ktsq_ctrl: sequencer that scans and shifts the table one slot per step.
// Depends on ktsq_pkg.
module ktsq_ctrl import ktsq_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 64,
  localparam int unsigned AW = $clog2(TABLE_DEPTH),
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  req_t          req_i,
  input  sts_t          sts_i,
  input  logic [CW-1:0] count_i,
  output cmd_t          cmd_o,
  output logic [AW-1:0] rd_addr_o,
  output logic [AW-1:0] wr_addr_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FRD   = 4'd1;  // find: read issued
  localparam logic [3:0] S_FCHK  = 4'd2;  // find: compare
  localparam logic [3:0] S_RMRD  = 4'd3;  // remove: read i+1
  localparam logic [3:0] S_RMWR  = 4'd4;  // remove: write i
  localparam logic [3:0] S_PRD   = 4'd5;  // add: position scan read
  localparam logic [3:0] S_PCHK  = 4'd6;
  localparam logic [3:0] S_ISRD  = 4'd7;  // add: read i-1
  localparam logic [3:0] S_ISWR  = 4'd8;  // add: write i
  localparam logic [3:0] S_POPRD = 4'd9;
  localparam logic [3:0] S_POPCK = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] pos_q, pos_d;
  logic          busy_q, busy_d;   // output register holds an unsent result
  logic [1:0]    kind;
  logic [CW-1:0] idx_p1;
  logic          rsp_go;

  assign kind   = req_i.kind;
  assign idx_p1 = idx_q + CW'(1);

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    pos_d    = pos_q;
    cmd_o    = '0;
    rd_addr_o = idx_q[AW-1:0];
    wr_addr_o = idx_q[AW-1:0];
    rsp_go   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && !busy_q) begin
          cmd_o.load_req = 1'b1;
          state_d = S_FRD;
          idx_d   = '0;
        end
      end
      S_FRD: begin
        if (kind == OP_POP) begin
          state_d = S_POPRD;
        end else if (idx_q >= count_i) begin
          // key absent
          if (kind == OP_ADD) begin
            idx_d = '0;
            state_d = S_PRD;
          end else begin
            rsp_go = 1'b1;
            state_d = S_DONE;
          end
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d = S_FCHK;
        end
      end
      S_FCHK: begin
        if (sts_i.key_hit) begin
          if (kind == OP_EXISTS) begin
            cmd_o.set_rsp = 1'b1;
            cmd_o.rsp_ok  = 1'b1;
            state_d = S_DONE;
          end else begin
            state_d = S_RMRD;
          end
        end else begin
          idx_d = idx_p1;
          state_d = S_FRD;
        end
      end
      S_RMRD: begin
        if (idx_p1 >= count_i) begin
          cmd_o.cnt_dec = 1'b1;
          if (kind == OP_ADD) begin
            idx_d = '0;
            state_d = S_PRD;
          end else if (kind == OP_POP || kind == OP_DROP) begin
            if (kind == OP_DROP) begin
              cmd_o.set_rsp = 1'b1;
              cmd_o.rsp_ok  = 1'b1;
            end
            state_d = S_DONE;
          end
        end else begin
          cmd_o.rd_en = 1'b1;
          rd_addr_o = idx_p1[AW-1:0];
          state_d = S_RMWR;
        end
      end
      S_RMWR: begin
        cmd_o.wr_en = 1'b1;
        idx_d = idx_p1;
        state_d = S_RMRD;
      end
      S_PRD: begin
        if (count_i >= CW'(TABLE_DEPTH)) begin
          cmd_o.set_rsp = 1'b1;
          state_d = S_DONE;
        end else if (idx_q >= count_i) begin
          pos_d = idx_q;
          idx_d = count_i;
          state_d = S_ISRD;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d = S_PCHK;
        end
      end
      S_PCHK: begin
        if (sts_i.due_le) begin
          idx_d = idx_p1;
          state_d = S_PRD;
        end else begin
          pos_d = idx_q;
          idx_d = count_i;
          state_d = S_ISRD;
        end
      end
      S_ISRD: begin
        if (idx_q == pos_q) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_new = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          cmd_o.set_rsp = 1'b1;
          cmd_o.rsp_ok  = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.rd_en = 1'b1;
          rd_addr_o = AW'(idx_q - CW'(1));
          state_d = S_ISWR;
        end
      end
      S_ISWR: begin
        cmd_o.wr_en = 1'b1;
        idx_d = idx_q - CW'(1);
        state_d = S_ISRD;
      end
      S_POPRD: begin
        if (count_i == '0) begin
          rsp_go = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.rd_en = 1'b1;
          rd_addr_o = '0;
          state_d = S_POPCK;
        end
      end
      S_POPCK: begin
        if (sts_i.now_ok) begin
          cmd_o.set_rsp  = 1'b1;
          cmd_o.rsp_ok   = 1'b1;
          cmd_o.rsp_data = 1'b1;
          idx_d = '0;
          state_d = S_RMRD;
        end else begin
          rsp_go = 1'b1;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    if (rsp_go) begin
      cmd_o.set_rsp = 1'b1;  // failure result, all fields zero
    end
  end

  // result is posted when the sequence reaches S_DONE
  always_comb begin
    busy_d = busy_q;
    if (state_q == S_DONE) begin
      busy_d = 1'b1;
    end else if (busy_q && out_ready_i) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      pos_q   <= '0;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      pos_q   <= pos_d;
      busy_q  <= busy_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE) && !busy_q;
  assign out_valid_o = busy_q;

  a_done_posts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |=> busy_q) else $error("result not posted");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !in_ready_o) else $error("accept while result pending");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_i <= CW'(TABLE_DEPTH)) else $error("count overflow");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= CW'(TABLE_DEPTH)) else $error("index out of range");

endmodule

// File: hdl/keyed_timer_schedule_queue.sv
// keyed_timer_schedule_queue: due-time ordered event table keyed by address/type.
// The key search reads then compares each scanned slot, and a remove or insert
// shift reads then writes each moved slot.
// One item at a time: each step of the sequence issues at most one entry memory read.
// The next transfer is taken only once the previous result is taken.
// Reset (async, active low) empties the table at once via the slot count.
module keyed_timer_schedule_queue import ktsq_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  cmd_t          cmd;
  sts_t          sts;
  req_t          req;
  logic [CW-1:0] count;
  logic [AW-1:0] rd_addr, wr_addr;

  // sequencer: search, shift and insert one slot per step
  ktsq_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .req_i(req), .sts_i(sts), .count_i(count),
    .cmd_o(cmd), .rd_addr_o(rd_addr), .wr_addr_o(wr_addr)
  );

  // entry storage and result register
  ktsq_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .rd_addr_i(rd_addr), .wr_addr_i(wr_addr),
    .req_i(in_data_i), .req_o(req), .sts_o(sts),
    .count_o(count), .rsp_o(out_data_o)
  );

endmodule

// File: test/tb_keyed_timer_schedule_queue.sv
// tb_keyed_timer_schedule_queue: self-checking regression for the keyed timer schedule queue.
// Depends on ktsq_pkg (request/response types, op codes) and keyed_timer_schedule_queue.
`timescale 1ns / 100ps

module tb_keyed_timer_schedule_queue;
  import ktsq_pkg::*;

  localparam int unsigned DEPTH = 64;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  req_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_data_o;

  always #6 clk_i = ~clk_i;

  keyed_timer_schedule_queue #(.TABLE_DEPTH(DEPTH)) DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  // Shadow of the event table: entries kept packed at the front, in due order.
  entry_t sched[DEPTH];
  int unsigned sched_cnt = 0;
  rsp_t pending_rsp[$];
  int unsigned mismatch_cnt = 0;

  // Keys used by the random part come from a small pool so adds hit existing
  // entries, exists/drop find something, and the table actually fills up.
  logic [47:0] addr_pool[8];
  logic [7:0]  type_pool[4];

  function automatic int find_station(logic [47:0] a, logic [7:0] t);
    for (int i = 0; i < sched_cnt; i++)
      if (sched[i].addr == a && sched[i].etype == t) return i;
    return -1;
  endfunction

  function automatic void unlink_slot(int pos);
    for (int i = pos; i + 1 < sched_cnt; i++) sched[i] = sched[i+1];
    sched_cnt--;
  endfunction

  // Apply one request to the shadow table and return the expected response.
  function automatic rsp_t schedule_step(req_t r);
    rsp_t o;
    int pos;
    o = '0;
    case (r.kind)
      OP_ADD: begin
        pos = find_station(r.station_addr, r.event_type);
        if (pos >= 0) unlink_slot(pos);
        if (sched_cnt < DEPTH) begin
          pos = 0;
          // ties go behind every entry with an equal due time
          while (pos < sched_cnt && sched[pos].due <= r.due_time) pos++;
          for (int i = sched_cnt; i > pos; i--) sched[i] = sched[i-1];
          sched[pos] = '{due: r.due_time, addr: r.station_addr,
                         etype: r.event_type, pay: r.payload};
          sched_cnt++;
          o.ok = 1'b1;
        end
      end
      OP_POP: begin
        if (sched_cnt > 0 && sched[0].due <= r.now_time) begin
          o = '{ok: 1'b1, out_addr: sched[0].addr, out_type: sched[0].etype,
                out_payload: sched[0].pay};
          unlink_slot(0);
        end
      end
      OP_EXISTS: o.ok = (find_station(r.station_addr, r.event_type) >= 0);
      default: begin
        pos = find_station(r.station_addr, r.event_type);
        if (pos >= 0) begin
          unlink_slot(pos);
          o.ok = 1'b1;
        end
      end
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  // Send one request: random gap, then hold valid until the transfer happens.
  // Valid drops only when a gap follows, so back-to-back sends keep it high.
  task automatic send_req(req_t r);
    int gap;
    gap = $urandom_range(16);
    if ($urandom_range(3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (!in_ready_o);
    // expectation is queued at the transfer edge, before any result can appear
    pending_rsp.push_back(schedule_step(r));
  endtask

  // Receiver: random stall per result, then compare with the oldest expectation.
  initial begin
    int stall;
    rsp_t want;
    forever begin
      stall = $urandom_range(16);
      if ($urandom_range(3) == 0) stall = 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_data_o.out_payload), '0);
      end else begin
        want = pending_rsp.pop_front();
        if (out_data_o.ok !== want.ok)
          report_mismatch("ok", 64'(out_data_o.ok), 64'(want.ok));
        if (out_data_o.out_addr !== want.out_addr)
          report_mismatch("out_addr", 64'(out_data_o.out_addr), 64'(want.out_addr));
        if (out_data_o.out_type !== want.out_type)
          report_mismatch("out_type", 64'(out_data_o.out_type), 64'(want.out_type));
        if (out_data_o.out_payload !== want.out_payload)
          report_mismatch("out_payload", 64'(out_data_o.out_payload),
                          64'(want.out_payload));
      end
    end
  end

  function automatic req_t make_req(logic [1:0] k, logic [63:0] due, logic [63:0] now,
                                    logic [47:0] a, logic [7:0] t, logic [31:0] p);
    return '{kind: k, due_time: due, now_time: now, station_addr: a,
             event_type: t, payload: p};
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic req_t random_req();
    req_t r;
    logic [2:0] sel;
    r = make_req(2'($urandom_range(3)), rand64(), rand64(), 48'({$urandom, $urandom}),
                 8'($urandom), $urandom);
    sel = 3'($urandom_range(7));
    // mostly pooled keys so the table state matters; the rest fully random
    if (sel != 0) begin
      r.station_addr = addr_pool[$urandom_range(7)];
      r.event_type   = type_pool[$urandom_range(3)];
    end
    // small due/now window gives ties and a mix of due and not-yet-due pops
    if ($urandom_range(4) != 0) begin
      r.due_time = 64'($urandom_range(200));
      r.now_time = 64'($urandom_range(220));
    end
    return r;
  endfunction

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  // Directed: extremes of every field, each op, empty pop, absent key, ties.
  task automatic test_directed();
    send_req(make_req(OP_POP, '0, '1, '0, '0, '0));            // pop on empty table
    send_req(make_req(OP_EXISTS, '0, '0, '1, '1, '0));         // absent key
    send_req(make_req(OP_DROP, '1, '1, '1, '1, '1));           // drop absent
    send_req(make_req(OP_ADD, '1, '0, '1, '1, '1));            // max fields
    send_req(make_req(OP_ADD, '0, '1, '0, '0, '0));            // min fields
    send_req(make_req(OP_ADD, 64'd5, '0, 48'h1, 8'h1, 32'hA));
    send_req(make_req(OP_ADD, 64'd5, '0, 48'h2, 8'h1, 32'hB)); // tie: goes behind
    send_req(make_req(OP_ADD, 64'd3, '0, 48'h2, 8'h1, 32'hC)); // re-add same key
    send_req(make_req(OP_EXISTS, '0, '0, '1, '1, '0));
    send_req(make_req(OP_POP, '0, '0, '0, '0, '0));            // due-zero entry pops
    send_req(make_req(OP_POP, '0, 64'd2, '0, '0, '0));         // not yet due
    send_req(make_req(OP_POP, '0, 64'd3, '0, '0, '0));
    send_req(make_req(OP_POP, '0, 64'd5, '0, '0, '0));
    send_req(make_req(OP_DROP, '0, '0, '1, '1, '0));
    send_req(make_req(OP_POP, '0, '1, '0, '0, '0));
    send_req(make_req(OP_POP, '0, '1, '0, '0, '0));            // empty again
  endtask

  // Fill the table past full: the extra adds fail, a re-add of a held key works.
  task automatic test_full_table();
    for (int i = 0; i < DEPTH + 2; i++)
      send_req(make_req(OP_ADD, 64'($urandom_range(40)), '0, 48'(i + 100), 8'h7, $urandom));
    send_req(make_req(OP_ADD, 64'd1, '0, 48'd100, 8'h7, 32'h55));
    wait_drained();  // sender holds off until every result is back
    for (int i = 0; i < DEPTH + 1; i++) send_req(make_req(OP_POP, '0, '1, '0, '0, '0));
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      send_req(random_req());
      if ($urandom_range(150) == 0) wait_drained();
    end
  endtask

  initial begin
    for (int i = 0; i < 8; i++) addr_pool[i] = {$urandom, $urandom};
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int i = 0; i < 4; i++) type_pool[i] = 8'($urandom);
    type_pool[0] = '0;
    type_pool[1] = '1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_table();
    test_random(1500);
    wait_drained();
    repeat (300) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_rsp.size() == 0)
      $display("keyed_timer_schedule_queue regression: pass");
    else
      $display("keyed_timer_schedule_queue regression: fail");
    $finish;
  end

  // Watchdog for ~1650 items, each with its block time plus the longest gap and stall, at 12 ns a clock, times ~5.
  initial begin
    #30ms;
    $display("keyed_timer_schedule_queue regression: fail");
    $finish;
  end

endmodule
